### design/mlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlc_pkg;

	localparam int NUM_CORES  = 4;
	localparam int DATA_WIDTH = 32;
	localparam int CORE_W     = 2;
	localparam int FIELD_W    = 32;
	localparam int CIDX_W     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int CNT_W      = $clog2(NUM_CORES + 1);
	localparam int MEM_RESET  = 10;

	typedef enum logic [1:0] {
		ST_M = 2'd0,
		ST_E = 2'd1,
		ST_S = 2'd2,
		ST_I = 2'd3
	} line_st_t;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_EVICT = 2'd2
	} op_t;

	typedef struct packed {
		line_st_t [NUM_CORES-1:0]                 st;
		logic     [NUM_CORES-1:0][DATA_WIDTH-1:0] val;
		logic     [DATA_WIDTH-1:0]                mem;
	} line_regs_t;

	typedef struct packed {
		logic [FIELD_W-1:0] read_data;
		line_st_t           requester_state;
		logic [FIELD_W-1:0] memory_data;
		logic               coherent;
	} rsp_t;

	function automatic line_regs_t lines_reset();
		line_regs_t r;
		for (int k = 0; k < NUM_CORES; k++) begin
			r.st[k]  = ST_I;
			r.val[k] = '0;
		end
		r.mem = DATA_WIDTH'(MEM_RESET);
		return r;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] from_field(input logic [FIELD_W-1:0] x);
		logic [63:0] t;
		t = 64'(signed'(x));
		return t[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] to_field(input logic [DATA_WIDTH-1:0] x);
		logic [63:0] t;
		t = 64'(x);
		return t[FIELD_W-1:0];
	endfunction

endpackage

`default_nettype wire

### design/mlc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mlc_req_if import mlc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [CORE_W-1:0]  core;
	logic [FIELD_W-1:0] write_value;

	modport source (output valid, output operation, output core, output write_value,
		input ready);
	modport sink (input valid, input operation, input core, input write_value,
		output ready);
endinterface

interface mlc_rsp_if import mlc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] read_data;
	logic [1:0]         requester_state;
	logic [FIELD_W-1:0] memory_data;
	logic               coherent;

	modport source (output valid, output read_data, output requester_state,
		output memory_data, output coherent, input ready);
	modport sink (input valid, input read_data, input requester_state,
		input memory_data, input coherent, output ready);
endinterface

`default_nettype wire

### design/mlc_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module mlc_engine import mlc_pkg::*; (
	input  line_regs_t         cur,
	input  logic [1:0]         operation,
	input  logic [CORE_W-1:0]  core,
	input  logic [FIELD_W-1:0] write_value,
	output line_regs_t         nxt,
	output rsp_t               rsp
);

	logic                  core_ok;
	logic [CIDX_W-1:0]     cidx;
	line_st_t              cst;
	logic [DATA_WIDTH-1:0] wv;
	logic [DATA_WIDTH-1:0] rd;
	logic                  sup_found;
	logic [CIDX_W-1:0]     sup_idx;
	logic [CNT_W-1:0]      s_left;
	logic [CNT_W-1:0]      nm, ne, ns, ni;

	assign core_ok = (32'(core) < 32'(NUM_CORES));
	assign cidx    = CIDX_W'(core);
	assign cst     = cur.st[cidx];
	assign wv      = from_field(write_value);

	// snoop: lowest other core holding a valid copy
	always_comb begin
		sup_found = 1'b0;
		sup_idx   = '0;
		for (int k = NUM_CORES - 1; k >= 0; k--) begin
			if (CIDX_W'(k) != cidx && cur.st[k] != ST_I) begin
				sup_found = 1'b1;
				sup_idx   = CIDX_W'(k);
			end
		end
	end

	always_comb begin
		nxt    = cur;
		rd     = '0;
		s_left = '0;
		if (core_ok) begin
			unique case (operation)
				OP_READ: begin
					if (cst != ST_I) begin
						rd = cur.val[cidx];
					end else if (sup_found) begin
						if (cur.st[sup_idx] == ST_M) begin
							nxt.mem = cur.val[sup_idx];
						end
						nxt.st[sup_idx] = ST_S;
						nxt.st[cidx]    = ST_S;
						nxt.val[cidx]   = cur.val[sup_idx];
						rd              = cur.val[sup_idx];
					end else begin
						nxt.st[cidx]  = ST_E;
						nxt.val[cidx] = cur.mem;
						rd            = cur.mem;
					end
				end
				OP_WRITE: begin
					if (cst == ST_S || cst == ST_I) begin
						for (int k = 0; k < NUM_CORES; k++) begin
							if (CIDX_W'(k) != cidx) begin
								if (cur.st[k] == ST_M) begin
									nxt.mem = cur.val[k];
								end
								nxt.st[k] = ST_I;
							end
						end
					end
					nxt.st[cidx]  = ST_M;
					nxt.val[cidx] = wv;
				end
				OP_EVICT: begin
					if (cst != ST_I) begin
						if (cst == ST_M) begin
							nxt.mem = cur.val[cidx];
						end
						nxt.st[cidx] = ST_I;
						if (cst == ST_S) begin
							for (int k = 0; k < NUM_CORES; k++) begin
								if (nxt.st[k] == ST_S) begin
									s_left = s_left + CNT_W'(1);
								end
							end
							// sole sharer left takes exclusive
							if (s_left == CNT_W'(1)) begin
								for (int k = 0; k < NUM_CORES; k++) begin
									if (nxt.st[k] == ST_S) begin
										nxt.st[k] = ST_E;
									end
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		nm = '0;
		ne = '0;
		ns = '0;
		ni = '0;
		for (int k = 0; k < NUM_CORES; k++) begin
			unique case (nxt.st[k])
				ST_M: nm = nm + CNT_W'(1);
				ST_E: ne = ne + CNT_W'(1);
				ST_S: ns = ns + CNT_W'(1);
				ST_I: ni = ni + CNT_W'(1);
			endcase
		end
	end

	always_comb begin
		rsp.read_data       = to_field(rd);
		rsp.requester_state = core_ok ? nxt.st[cidx] : ST_I;
		rsp.memory_data     = to_field(nxt.mem);
		rsp.coherent        = (ni == CNT_W'(NUM_CORES))
			|| ((nm == CNT_W'(1) || ne == CNT_W'(1)) && ni == CNT_W'(NUM_CORES - 1))
			|| (ns >= CNT_W'(2) && ni == CNT_W'(NUM_CORES) - ns);
	end

endmodule

`default_nettype wire

### design/mesi_line_coherence.sv
`timescale 1ns / 1ps
`default_nettype none
// mesi_line_coherence: one memory line shared by the private caches of the cores
// req channel: operation (read, write, evict), requesting core and write data
// rsp channel: read data, requester's new state, memory copy, legality flag
// one rsp beat for every req beat, in order
// a req beat lands in the input register; the snoop and update logic then
// runs on it and the result goes to the output register with the new line state
// throughput: one beat per cycle while rsp is ready, set by the single pass through the snoop logic
// the input register takes a new beat when it is empty or its beat moves to the
// output register in the same cycle
// when rsp stalls, the held result stays and one more req beat is buffered,
// then req.ready drops until rsp is taken
// reset: all cores invalid, cached values zero, memory copy ten, both
// registers empty

module mesi_line_coherence import mlc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mlc_req_if.sink     req,
	mlc_rsp_if.source   rsp
);

	logic               req_valid_s1;
	logic [1:0]         operation_s1;
	logic [CORE_W-1:0]  core_s1;
	logic [FIELD_W-1:0] write_value_s1;
	logic               adv;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	line_regs_t         lines_q;
	line_regs_t         lines_nxt;
	rsp_t               rsp_nxt;

	assign adv       = req_valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !req_valid_s1 || adv;

	mlc_engine u_engine (
		.cur         (lines_q),
		.operation   (operation_s1),
		.core        (core_s1),
		.write_value (write_value_s1),
		.nxt         (lines_nxt),
		.rsp         (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			req_valid_s1 <= 1'b1;
		end else if (adv) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			operation_s1   <= req.operation;
			core_s1        <= req.core;
			write_value_s1 <= req.write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q     <= lines_reset();
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			lines_q     <= lines_nxt;
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.read_data       = rsp_q.read_data;
	assign rsp.requester_state = rsp_q.requester_state;
	assign rsp.memory_data     = rsp_q.memory_data;
	assign rsp.coherent        = rsp_q.coherent;

`ifndef NO_ASSERTIONS
	a_coherent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.coherent)
		else $error("illegal state combination reported");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid_q)
		else $error("result lost after advance");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid_s1 && !adv) |=> (req_valid_s1 && $stable(core_s1)))
		else $error("stalled input beat dropped");

	a_state_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(lines_q))
		else $error("line state changed without an advancing beat");
`endif

endmodule

`default_nettype wire
